// ===== hdl/pbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and helpers of the pixel bin downsampler.
// ----------------------------------------------------------------------------
package pbd_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 4096;
	localparam int unsigned MAX_BIN_DEF   = 16;
	localparam int unsigned HEIGHT_LIMIT  = 4096;
	localparam int unsigned PIX_W         = 24;
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BIN    = 2'd2;
	localparam logic [1:0] REG_MODE   = 2'd3;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [4:0]  bin_factor;
		logic        subsample_mode;
	} pbd_cfg_t;

	typedef struct packed {
		logic direct;
		logic add;
		logic fin;
		logic last;
	} pbd_ctl_t;

	typedef struct packed {
		logic busy;
		logic dividing;
	} pbd_bstat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_ADD,
		B_DIV,
		B_FIX,
		B_OUT
	} pbd_bstate_t;

	function automatic logic [15:0] clamp(logic [15:0] v, logic [15:0] hi);
		logic [15:0] r;
		if (v == 16'd0) r = 16'd1;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pbd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_pix_if / pbd_bin_if
// Valid/ready channels for input pixels and binned results.
// ----------------------------------------------------------------------------
interface pbd_pix_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface pbd_bin_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] binned_value;
	logic               last_of_frame;
	modport source (output valid, output binned_value, output last_of_frame, input ready);
	modport sink (input valid, input binned_value, input last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== hdl/pbd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module pbd_queue #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = pbd_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              full,
	output logic              empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/pbd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_front
// Accepts pixels, tracks block position, accumulates row sums, issues work.
// ----------------------------------------------------------------------------
module pbd_front #(
	parameter int unsigned MAX_WIDTH = pbd_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_BIN   = pbd_pkg::MAX_BIN_DEF,
	parameter int unsigned SUM_W     = 32,
	parameter int unsigned IDX_W     = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pbd_pkg::pbd_cfg_t cfg,
	input  wire logic              restart,
	pbd_pix_if.sink                pixel_in,
	input  wire logic              full,
	output logic                   push,
	output pbd_pkg::pbd_ctl_t      push_ctl,
	output logic [SUM_W-1:0]       push_value,
	output logic [IDX_W-1:0]       push_idx
);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1) + 2;
	localparam int unsigned RW = $clog2(pbd_pkg::HEIGHT_LIMIT + 1) + 2;
	localparam int unsigned PW = $clog2(MAX_BIN);
	localparam int unsigned BW = $clog2(MAX_BIN + 1);

	logic [CW-1:0]          col_base_q, w, bc, x1;
	logic [RW-1:0]          row_base_q, h, br, y1;
	logic [PW-1:0]          col_ph_q, row_ph_q;
	logic [IDX_W-1:0]       col_pos_q;
	logic signed [SUM_W-1:0] row_sum_q, px, rs;
	logic [BW-1:0]          b;
	logic                   whole, last_blk, accept, col_end, row_end, emit;

	always_comb begin
		w  = CW'(pbd_pkg::clamp(16'(cfg.image_width), 16'(MAX_WIDTH)));
		h  = RW'(pbd_pkg::clamp(16'(cfg.image_height), 16'(pbd_pkg::HEIGHT_LIMIT)));
		b  = BW'(pbd_pkg::clamp(16'(cfg.bin_factor), 16'(MAX_BIN)));
		bc = CW'(b);
		br = RW'(b);
		whole    = (col_base_q + bc <= w) && (row_base_q + br <= h);
		last_blk = (col_base_q + bc + bc > w) && (row_base_q + br + br > h);
		x1       = col_base_q + CW'(col_ph_q) + 1'b1;
		y1       = row_base_q + RW'(row_ph_q) + 1'b1;
		px       = SUM_W'(pixel_in.pixel);
		rs       = (col_ph_q == '0) ? px : row_sum_q + px;
		col_end  = (BW'(col_ph_q) + 1'b1 == b);
		row_end  = (BW'(row_ph_q) + 1'b1 == b);
		pixel_in.ready = !full;
		accept   = pixel_in.valid && !full;

		push_ctl   = '0;
		push_value = rs;
		push_idx   = col_pos_q;
		emit       = 1'b0;
		if (cfg.subsample_mode) begin
			emit            = whole && (col_ph_q == '0) && (row_ph_q == '0);
			push_ctl.direct = 1'b1;
			push_value      = px;
		end else begin
			emit = whole && col_end;
		end
		push_ctl.add  = (row_ph_q != '0);
		push_ctl.fin  = row_end;
		push_ctl.last = last_blk;
		push = accept && emit;
	end

	always_ff @(posedge clk) begin
		if (accept && whole && !cfg.subsample_mode) row_sum_q <= rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_base_q <= '0;
			col_ph_q   <= '0;
			col_pos_q  <= '0;
			row_base_q <= '0;
			row_ph_q   <= '0;
		end else if (restart) begin
			col_base_q <= '0;
			col_ph_q   <= '0;
			col_pos_q  <= '0;
			row_base_q <= '0;
			row_ph_q   <= '0;
		end else if (accept) begin
			if (x1 >= w) begin
				col_base_q <= '0;
				col_ph_q   <= '0;
				col_pos_q  <= '0;
				if (y1 >= h) begin
					row_base_q <= '0;
					row_ph_q   <= '0;
				end else if (row_end) begin
					row_ph_q   <= '0;
					row_base_q <= row_base_q + br;
				end else begin
					row_ph_q <= row_ph_q + 1'b1;
				end
			end else if (col_end) begin
				col_ph_q   <= '0;
				col_base_q <= col_base_q + bc;
				col_pos_q  <= col_pos_q + 1'b1;
			end else begin
				col_ph_q <= col_ph_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/pbd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pbd_back
// Merges row sums with the line store, divides block totals, drives results.
// ----------------------------------------------------------------------------
module pbd_back #(
	parameter int unsigned MAX_BIN = pbd_pkg::MAX_BIN_DEF,
	parameter int unsigned SUM_W   = 32,
	parameter int unsigned IDX_W   = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pbd_pkg::pbd_cfg_t cfg,
	input  wire logic              empty,
	input  wire pbd_pkg::pbd_ctl_t pop_ctl,
	input  wire logic [SUM_W-1:0]  pop_value,
	input  wire logic [IDX_W-1:0]  pop_idx,
	output logic                   pop,
	output pbd_pkg::pbd_bstat_t    stat,
	pbd_bin_if.source              bin_out
);
	localparam int unsigned BW    = $clog2(MAX_BIN + 1);
	localparam int unsigned DW    = 2 * BW;
	localparam int unsigned MW    = SUM_W + 1;
	localparam int unsigned NW    = $clog2(MW + 1);
	localparam int unsigned DEPTH = 2 ** IDX_W;

	pbd_pkg::pbd_bstate_t    state_q, state_d;
	logic [SUM_W-1:0]        mem [DEPTH];
	logic [SUM_W-1:0]        rd_q;
	pbd_pkg::pbd_ctl_t       ctl_q;
	logic signed [SUM_W-1:0] val_q, total;
	logic [IDX_W-1:0]        idx_q;
	logic [BW-1:0]           b;
	logic [DW-1:0]           den;
	logic signed [MW-1:0]    tot_ext;
	logic [MW-1:0]           mag, num_q;
	logic [DW:0]             rem_q, rem_sh;
	logic [NW-1:0]           cnt_q;
	logic                    neg_q, ge;
	logic [23:0]             res_q, quo;
	logic                    last_q;

	always_comb begin
		b       = BW'(pbd_pkg::clamp(16'(cfg.bin_factor), 16'(MAX_BIN)));
		den     = DW'(b) * DW'(b);
		total   = val_q + (ctl_q.add ? $signed(rd_q) : '0);
		tot_ext = MW'(total);
		mag     = total[SUM_W-1] ? MW'(-tot_ext + $signed(MW'(den)) - 1) : MW'(tot_ext);
		rem_sh  = {rem_q[DW-1:0], num_q[MW-1]};
		ge      = (rem_sh >= (DW+1)'(den));
		quo     = num_q[23:0];
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			pbd_pkg::B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (pop_ctl.direct) state_d = pbd_pkg::B_OUT;
					else if (pop_ctl.add) state_d = pbd_pkg::B_READ;
					else state_d = pbd_pkg::B_ADD;
				end
			end
			pbd_pkg::B_READ: state_d = pbd_pkg::B_ADD;
			pbd_pkg::B_ADD:  state_d = ctl_q.fin ? pbd_pkg::B_DIV : pbd_pkg::B_IDLE;
			pbd_pkg::B_DIV:  if (cnt_q == NW'(MW - 1)) state_d = pbd_pkg::B_FIX;
			pbd_pkg::B_FIX:  state_d = pbd_pkg::B_OUT;
			pbd_pkg::B_OUT:  if (bin_out.ready) state_d = pbd_pkg::B_IDLE;
			default:         state_d = pbd_pkg::B_IDLE;
		endcase
		stat.busy     = (state_q != pbd_pkg::B_IDLE);
		stat.dividing = (state_q == pbd_pkg::B_DIV);
		bin_out.valid         = (state_q == pbd_pkg::B_OUT);
		bin_out.binned_value  = res_q;
		bin_out.last_of_frame = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pbd_pkg::B_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == pbd_pkg::B_READ) rd_q <= mem[idx_q];
		if (state_q == pbd_pkg::B_ADD && !ctl_q.fin) mem[idx_q] <= total;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pbd_pkg::B_IDLE: begin
				ctl_q  <= pop_ctl;
				val_q  <= pop_value;
				idx_q  <= pop_idx;
				res_q  <= pop_value[23:0];
				last_q <= pop_ctl.last;
			end
			pbd_pkg::B_ADD: begin
				neg_q <= total[SUM_W-1];
				num_q <= mag;
				rem_q <= '0;
				cnt_q <= '0;
			end
			pbd_pkg::B_DIV: begin
				rem_q <= ge ? rem_sh - (DW+1)'(den) : rem_sh;
				num_q <= {num_q[MW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			pbd_pkg::B_FIX: res_q <= neg_q ? -quo : quo;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/pixel_bin_downsampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_bin_downsampler
// BxB box-average or top-left subsampling of a raster pixel stream.
// ----------------------------------------------------------------------------
// The front takes one pixel per cycle while its four-word queue has room.
// Subsample words and row-segment sums go through the queue to the back,
// which takes one word at a time: it sends a subsample word out directly,
// adds a sum to the line store, or divides a finished block total with its
// one-bit-per-cycle divider, and then waits on the result handshake for each
// result. No clearing pass follows reset.
module pixel_bin_downsampler #(
	parameter int unsigned MAX_WIDTH = pbd_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_BIN   = pbd_pkg::MAX_BIN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	pbd_pix_if.sink          pixel_in,
	pbd_bin_if.source        bin_out
);
	localparam int unsigned SUM_W = pbd_pkg::PIX_W + 2 * $clog2(MAX_BIN);
	localparam int unsigned IDX_W = $clog2(MAX_WIDTH / 2);
	localparam int unsigned QW    = $bits(pbd_pkg::pbd_ctl_t) + SUM_W + IDX_W;

	pbd_pkg::pbd_cfg_t   cfg_q;
	pbd_pkg::pbd_ctl_t   push_ctl, pop_ctl;
	pbd_pkg::pbd_bstat_t bstat;
	logic [SUM_W-1:0]    push_value, pop_value;
	logic [IDX_W-1:0]    push_idx, pop_idx;
	logic [QW-1:0]       pop_data;
	logic                wr, push, pop, full, empty;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= 13'd4096;
			cfg_q.image_height   <= 13'd4096;
			cfg_q.bin_factor     <= 5'd2;
			cfg_q.subsample_mode <= 1'b0;
		end else if (wr) begin
			case (paddr[3:2])
				pbd_pkg::REG_WIDTH:  cfg_q.image_width    <= pwdata[12:0];
				pbd_pkg::REG_HEIGHT: cfg_q.image_height   <= pwdata[12:0];
				pbd_pkg::REG_BIN:    cfg_q.bin_factor     <= pwdata[4:0];
				pbd_pkg::REG_MODE:   cfg_q.subsample_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pbd_pkg::REG_WIDTH:  prdata = 32'(cfg_q.image_width);
			pbd_pkg::REG_HEIGHT: prdata = 32'(cfg_q.image_height);
			pbd_pkg::REG_BIN:    prdata = 32'(cfg_q.bin_factor);
			pbd_pkg::REG_MODE:   prdata = 32'(cfg_q.subsample_mode);
			default:             prdata = '0;
		endcase
	end

	pbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_BIN(MAX_BIN), .SUM_W(SUM_W), .IDX_W(IDX_W))
	u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .restart(wr), .pixel_in(pixel_in),
		.full(full), .push(push), .push_ctl(push_ctl), .push_value(push_value),
		.push_idx(push_idx)
	);

	pbd_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push),
		.push_data({push_ctl, push_value, push_idx}),
		.pop(pop), .pop_data(pop_data), .full(full), .empty(empty)
	);

	assign {pop_ctl, pop_value, pop_idx} = pop_data;

	pbd_back #(.MAX_BIN(MAX_BIN), .SUM_W(SUM_W), .IDX_W(IDX_W)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .empty(empty), .pop_ctl(pop_ctl),
		.pop_value(pop_value), .pop_idx(pop_idx), .pop(pop), .stat(bstat),
		.bin_out(bin_out)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> bstat.busy) else $error("back idle after pop");
	a_no_out_div: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.dividing |-> !bin_out.valid) else $error("result during divide");
endmodule
`default_nettype wire

// ===== test/pixel_bin_downsampler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_bin_downsampler_tb
// Drives random and directed frames of Q16.8 pixels through the downsampler
// under several block sizes, image sizes and both modes, with random input
// bursts and output stalls, and checks every binned word against a local
// predictor of block averages and top-left subsamples.
// ----------------------------------------------------------------------------
module pixel_bin_downsampler_tb;

	localparam int unsigned IDLE_WAIT = 200;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [23:0] value;
		logic               last;
	} bin_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pbd_pix_if pix ();
	pbd_bin_if bin ();

	pixel_bin_downsampler dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel_in(pix.sink), .bin_out(bin.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [12:0] cfg_width = 13'd4096, cfg_height = 13'd4096;
	logic [4:0]  cfg_bin = 5'd2;
	logic        cfg_sub = 1'b0;
	longint      col_sum_store [2048];
	longint      seg_sum;
	int unsigned blk_col, blk_row, col_ph, row_ph;

	logic signed [23:0] pending_pixels [$];
	bin_word_t          expected_bins [$];
	int                 errors = 0;
	int                 words_in = 0, words_out = 0, last_seen = 0;
	int                 idle_cycles = 0;
	bit                 stim_done = 1'b0;

	function automatic int unsigned clip(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint floor_quot(longint num, longint den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic void restart_frame();
		seg_sum = 0;
		blk_col = 0; blk_row = 0; col_ph = 0; row_ph = 0;
	endfunction

	function automatic void predict_bin(logic signed [23:0] px);
		int unsigned w, h, b, x, y;
		longint total;
		bit whole, last_blk;
		bin_word_t r;
		w = clip(cfg_width, 4096);
		h = clip(cfg_height, 4096);
		b = clip(cfg_bin, 16);
		x = blk_col * b + col_ph;
		y = blk_row * b + row_ph;
		whole = blk_col < w / b && blk_row < h / b;
		last_blk = blk_col + 1 == w / b && blk_row + 1 == h / b;
		if (whole) begin
			if (cfg_sub) begin
				if (col_ph == 0 && row_ph == 0) begin
					r.value = px; r.last = last_blk;
					expected_bins.push_back(r);
				end
			end else begin
				if (col_ph == 0) seg_sum = px;
				else seg_sum += px;
				if (col_ph + 1 == b) begin
					total = seg_sum;
					if (row_ph != 0) total += col_sum_store[blk_col % 2048];
					if (row_ph + 1 == b) begin
						r.value = 24'(floor_quot(total, longint'(b * b)));
						r.last = last_blk;
						expected_bins.push_back(r);
					end else begin
						col_sum_store[blk_col % 2048] = total;
					end
				end
			end
		end
		if (x + 1 >= w) begin
			blk_col = 0; col_ph = 0;
			if (y + 1 >= h) begin
				blk_row = 0; row_ph = 0;
			end else if (++row_ph >= b) begin
				row_ph = 0; blk_row++;
			end
		end else if (++col_ph >= b) begin
			col_ph = 0; blk_col++;
		end
	endfunction

	// driver: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			predict_bin(pix.pixel);
			words_in++;
			void'(pending_pixels.pop_front());
		end
		if (pix.valid && !pix.ready) begin
		end else if (gap_left > 0) begin
			gap_left--;
			pix.valid <= 1'b0;
		end else if ((pix.valid && pix.ready ? pending_pixels.size() : pending_pixels.size()) != 0
			&& arst_n) begin
			pix.valid <= 1'b1;
			pix.pixel <= pending_pixels[0];
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
			end else if (--burst_left == 0 && $urandom_range(0, 2) != 0) begin
				gap_left = $urandom_range(1, 6);
			end
		end else begin
			pix.valid <= 1'b0;
		end
	end

	// receiver stall pattern and checker
	int stall_phase = 0;
	always @(posedge clk) begin
		bin_word_t e;
		stall_phase <= stall_phase + 1;
		bin.ready <= (stall_phase % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
		if (bin.valid && bin.ready) begin
			words_out++;
			if (bin.last_of_frame) last_seen++;
			if (expected_bins.size() == 0) begin
				$error("binned word with nothing expected: value %0d", bin.binned_value);
				errors++;
			end else begin
				e = expected_bins.pop_front();
				if (bin.binned_value !== e.value) begin
					$error("binned_value expected %0d actual %0d", e.value, bin.binned_value);
					errors++;
				end
				if (bin.last_of_frame !== e.last) begin
					$error("last_of_frame expected %0d actual %0d", e.last, bin.last_of_frame);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (bin.valid && bin.ready) || psel) idle_cycles <= 0;
		else if (!stim_done || expected_bins.size() != 0) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("** pixel_bin_downsampler: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			pbd_pkg::REG_WIDTH: cfg_width = value[12:0];
			pbd_pkg::REG_HEIGHT: cfg_height = value[12:0];
			pbd_pkg::REG_BIN: cfg_bin = value[4:0];
			default: cfg_sub = value[0];
		endcase
		restart_frame();
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || pix.valid || expected_bins.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic configure(int w, int h, int b, int s);
		drain();
		write_reg(pbd_pkg::REG_WIDTH, w);
		write_reg(pbd_pkg::REG_HEIGHT, h);
		write_reg(pbd_pkg::REG_BIN, b);
		write_reg(pbd_pkg::REG_MODE, s);
	endtask

	function automatic logic signed [23:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic push_pixels(int n);
		repeat (n) pending_pixels.push_back(rand_pixel());
	endtask

	initial begin
		int w, h, b, frames;
		pix.valid = 1'b0;
		pix.pixel = '0;
		bin.ready = 1'b0;
		restart_frame();
		foreach (col_sum_store[i]) col_sum_store[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, pass-through, tiny image, zero registers, max bin
		configure(4, 2, 2, 0);
		repeat (8) pending_pixels.push_back(24'sh7FFFFF);
		repeat (8) pending_pixels.push_back(24'sh800000);
		configure(3, 1, 1, 0);
		pending_pixels.push_back(24'sh000001);
		pending_pixels.push_back(24'shFFFFFF);
		pending_pixels.push_back(24'sh555555);
		configure(1, 1, 2, 1);
		push_pixels(2);
		configure(0, 0, 0, 1);
		push_pixels(2);
		configure(16, 16, 31, 0);
		push_pixels(256);
		configure(17, 17, 16, 1);
		push_pixels(289);
		configure(8191, 1, 5, 1);
		push_pixels(20);
		configure(8191, 8191, 3, 0);
		push_pixels(30);

		// random frames
		while (words_in + pending_pixels.size() < 800) begin
			b = $urandom_range(0, 4) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 4);
			w = $urandom_range(1, 3 * b + 5);
			h = $urandom_range(1, 2 * b + 3);
			configure(w, h, b, $urandom_range(0, 1));
			frames = $urandom_range(1, 2);
			push_pixels(frames * w * h + $urandom_range(0, 2) * $urandom_range(0, w));
		end
		configure(4096, 4096, 2, 0);
		push_pixels(30);
		drain();
		stim_done = 1'b1;

		$display("covered %0d pixels in, %0d binned words out, %0d frame ends",
			words_in, words_out, last_seen);
		if (errors == 0 && expected_bins.size() == 0) $display("** pixel_bin_downsampler: PASSED **");
		else $display("** pixel_bin_downsampler: FAILED **");
		$finish;
	end
endmodule

// ===== pixel_bin_downsampler.f =====
hdl/pbd_pkg.sv
hdl/pbd_if.sv
hdl/pbd_queue.sv
hdl/pbd_front.sv
hdl/pbd_back.sv
hdl/pixel_bin_downsampler.sv
test/pixel_bin_downsampler_tb.sv
